[rtl/dsf_pkg.sv]
// Types and constants shared by the damped spring force block.
package dsf_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;
    localparam logic [30:0] MIN_DIST_RST = 31'd1;

    typedef struct packed {
        logic signed [31:0] delta_pos_x;
        logic signed [31:0] delta_pos_y;
        logic signed [31:0] delta_pos_z;
        logic signed [31:0] delta_vel_x;
        logic signed [31:0] delta_vel_y;
        logic signed [31:0] delta_vel_z;
        logic        [30:0] rest_length;
        logic signed [31:0] stiffness;
        logic signed [31:0] damping;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               too_close;
    } t_out_item;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [2:0][31:0] vel;
        logic [30:0]      rest;
        logic [31:0]      k;
        logic [31:0]      c;
    } t_sq_side;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][31:0] vel;
        logic [30:0]      rest;
        logic [31:0]      k;
        logic [31:0]      c;
        logic [31:0]      norm;
        logic             too_close;
    } t_dv_side;

endpackage

[rtl/dsf_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module dsf_sqrt import dsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_rad,
    input  t_sq_side    i_side,
    output logic        o_valid,
    output logic [31:0] o_root,
    output t_sq_side    o_side
);

    logic        r_val  [SQ_STEPS];
    logic [63:0] r_rad  [SQ_STEPS];
    logic [33:0] r_rem  [SQ_STEPS];
    logic [31:0] r_root [SQ_STEPS];
    t_sq_side    r_side [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_stage
        logic        s_val;
        logic [63:0] s_rad;
        logic [33:0] s_rem;
        logic [31:0] s_root;
        t_sq_side    s_side;
        logic [35:0] trial;
        logic [35:0] test;

        if (j == 0) begin : g_first
            assign s_val  = i_valid;
            assign s_rad  = i_rad;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_val  = r_val[j-1];
            assign s_rad  = r_rad[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_root = r_root[j-1];
            assign s_side = r_side[j-1];
        end

        assign trial = {s_rem, s_rad[63:62]};
        assign test  = {2'b00, s_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[j] <= 1'b0;
            end else if (i_en) begin
                r_val[j] <= s_val;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j]  <= {s_rad[61:0], 2'b00};
                r_side[j] <= s_side;
                if (trial >= test) begin
                    r_rem[j]  <= 34'(trial - test);
                    r_root[j] <= {s_root[30:0], 1'b1};
                end else begin
                    r_rem[j]  <= trial[33:0];
                    r_root[j] <= {s_root[30:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_val[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];

endmodule

[rtl/dsf_div.sv]
// Pipelined three-lane restoring divider giving the Q1.30 unit direction.
module dsf_div import dsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [2:0][31:0] i_mag,
    input  t_dv_side         i_side,
    output logic             o_valid,
    output logic [2:0][30:0] o_quo,
    output t_dv_side         o_side
);

    logic             r_val  [DIV_STEPS];
    logic [2:0][31:0] r_rem  [DIV_STEPS];
    logic [2:0][30:0] r_quo  [DIV_STEPS];
    logic [2:0][30:0] r_nb   [DIV_STEPS];
    t_dv_side         r_side [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
        logic             s_val;
        logic [2:0][31:0] s_rem;
        logic [2:0][30:0] s_quo;
        logic [2:0][30:0] s_nb;
        t_dv_side         s_side;
        logic [2:0][31:0] n_rem;
        logic [2:0][30:0] n_quo;

        if (j == 0) begin : g_first
            assign s_val  = i_valid;
            assign s_side = i_side;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign s_rem[l] = {1'b0, i_mag[l][31:1]};
                assign s_nb[l]  = {i_mag[l][0], 30'd0};
                assign s_quo[l] = '0;
            end
        end else begin : g_next
            assign s_val  = r_val[j-1];
            assign s_side = r_side[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_nb   = r_nb[j-1];
            assign s_quo  = r_quo[j-1];
        end

        always_comb begin
            logic [32:0] t;
            for (int l = 0; l < 3; l++) begin
                t = {s_rem[l], s_nb[l][30]};
                if (t >= {1'b0, s_side.norm}) begin
                    n_rem[l] = 32'(t - {1'b0, s_side.norm});
                    n_quo[l] = {s_quo[l][29:0], 1'b1};
                end else begin
                    n_rem[l] = t[31:0];
                    n_quo[l] = {s_quo[l][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[j] <= 1'b0;
            end else if (i_en) begin
                r_val[j] <= s_val;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_quo[j]  <= n_quo;
                r_side[j] <= s_side;
                for (int l = 0; l < 3; l++) begin
                    r_nb[j][l] <= {s_nb[l][29:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_val[DIV_STEPS-1];
    assign o_quo   = r_quo[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule

[rtl/dsf_force.sv]
// Arithmetic tail: axial velocity, spring and damper terms, force and saturation.
module dsf_force import dsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [2:0][30:0] i_quo,
    input  t_dv_side         i_side,
    output logic             o_valid,
    output t_out_item        o_data
);

    // stage 1
    logic                    r1_val;
    logic signed [2:0][31:0] r1_u;
    logic signed [63:0]      r1_prod [3];
    logic signed [33:0]      r1_ext;
    logic        [31:0]      r1_k, r1_c;
    logic                    r1_tc;
    // stage 2
    logic                    r2_val;
    logic signed [2:0][31:0] r2_u;
    logic signed [33:0]      r2_vax, r2_ext;
    logic        [31:0]      r2_k, r2_c;
    logic                    r2_tc;
    // stage 3
    logic                    r3_val;
    logic signed [2:0][31:0] r3_u;
    logic signed [65:0]      r3_pk, r3_pc;
    logic                    r3_tc;
    // stage 4
    logic                    r4_val;
    logic signed [2:0][31:0] r4_u;
    logic signed [49:0]      r4_s;
    logic                    r4_tc;
    // stage 5
    logic                    r5_val;
    logic signed [57:0]      r5_ph [3];
    logic signed [56:0]      r5_pl [3];
    logic                    r5_tc;
    // output
    logic                    r_o_valid;
    t_out_item               r_o_data;

    logic signed [2:0][31:0] n_u;
    logic signed [63:0]      n_dot;
    logic signed [31:0]      n_f [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_u[l] = i_side.neg[l] ? -{1'b0, i_quo[l]} : {1'b0, i_quo[l]};
        end
    end

    assign n_dot = r1_prod[0] + r1_prod[1] + r1_prod[2];

    always_comb begin
        logic signed [81:0] a;
        logic signed [81:0] b;
        logic signed [81:0] tot;
        for (int l = 0; l < 3; l++) begin
            a   = 82'(r5_ph[l]) <<< 24;
            b   = 82'(r5_pl[l]);
            tot = a + b;
            if ($signed(tot[81:30]) > 52'sd2147483647) begin
                n_f[l] = 32'sh7fffffff;
            end else if ($signed(tot[81:30]) < -52'sd2147483648) begin
                n_f[l] = 32'sh80000000;
            end else begin
                n_f[l] = tot[61:30];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_val    <= 1'b0;
            r2_val    <= 1'b0;
            r3_val    <= 1'b0;
            r4_val    <= 1'b0;
            r5_val    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r1_val    <= i_valid;
            r2_val    <= r1_val;
            r3_val    <= r2_val;
            r4_val    <= r3_val;
            r5_val    <= r4_val;
            r_o_valid <= r5_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_u   <= n_u;
            for (int l = 0; l < 3; l++) begin
                r1_prod[l] <= $signed(i_side.vel[l]) * $signed(n_u[l]);
            end
            r1_ext <= $signed({2'b00, i_side.norm}) - $signed({3'b000, i_side.rest});
            r1_k   <= i_side.k;
            r1_c   <= i_side.c;
            r1_tc  <= i_side.too_close;

            r2_u   <= r1_u;
            r2_vax <= n_dot[63:30];
            r2_ext <= r1_ext;
            r2_k   <= r1_k;
            r2_c   <= r1_c;
            r2_tc  <= r1_tc;

            r3_u   <= r2_u;
            r3_pk  <= $signed(r2_k) * r2_ext;
            r3_pc  <= $signed(r2_c) * r2_vax;
            r3_tc  <= r2_tc;

            r4_u   <= r3_u;
            r4_s   <= $signed(r3_pk[65:16]) + $signed(r3_pc[65:16]);
            r4_tc  <= r3_tc;

            for (int l = 0; l < 3; l++) begin
                r5_ph[l] <= $signed(r4_u[l]) * $signed(r4_s[49:24]);
                r5_pl[l] <= $signed(r4_u[l]) * $signed({1'b0, r4_s[23:0]});
            end
            r5_tc  <= r4_tc;

            r_o_data.too_close <= r5_tc;
            r_o_data.force_x   <= r5_tc ? '0 : n_f[0];
            r_o_data.force_y   <= r5_tc ? '0 : n_f[1];
            r_o_data.force_z   <= r5_tc ? '0 : n_f[2];
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

[rtl/damped_spring_force.sv]
// Top level of the damped spring force pipeline.
//
// One joint enters per transfer on the input channel (i_valid / o_stall,
// payload i_data): B minus A position and velocity, rest length, stiffness
// and damping, all Q16.16. One result leaves per joint on the output channel
// (o_valid / i_stall, payload o_data): the saturated force on body A and the
// too_close flag, which is set with zero force when the distance is zero or
// below min_distance.
// min_distance is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while no joint is in flight; the block does not enforce this.
// Pipeline stages: square sums 2, square root 32 (one bit a stage),
// direction divide 31 (one quotient bit a stage), force arithmetic 6.
// Throughput is one joint per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline and o_stall rises with it, so
// nothing is lost or repeated; the pipeline moves again once the result is
// taken.
// Synchronous reset empties the pipeline and sets min_distance to 1.
module damped_spring_force import dsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data
);

    logic             en;
    logic [30:0]      r_min_dist;
    logic             r_a_val;
    logic [63:0]      r_a_sq [3];
    t_sq_side         r_a_side;
    logic             r_b_val;
    logic [63:0]      r_b_sum;
    t_sq_side         r_b_side;
    t_sq_side         n_side;
    logic             sq_valid;
    logic [31:0]      sq_root;
    t_sq_side         sq_side;
    t_dv_side         dv_in;
    logic             dv_valid;
    logic [2:0][30:0] dv_quo;
    t_dv_side         dv_side;

    assign en      = ~(o_valid & i_stall);
    assign o_stall = ~en;

    always_comb begin
        logic [2:0][31:0] d;
        d = {i_data.delta_pos_z, i_data.delta_pos_y, i_data.delta_pos_x};
        for (int l = 0; l < 3; l++) begin
            n_side.neg[l] = d[l][31];
            n_side.mag[l] = d[l][31] ? -d[l] : d[l];
        end
        n_side.vel  = {i_data.delta_vel_z, i_data.delta_vel_y, i_data.delta_vel_x};
        n_side.rest = i_data.rest_length;
        n_side.k    = i_data.stiffness;
        n_side.c    = i_data.damping;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= MIN_DIST_RST;
        end else if (i_cfg_we) begin
            r_min_dist <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_val <= 1'b0;
            r_b_val <= 1'b0;
        end else if (en) begin
            r_a_val <= i_valid;
            r_b_val <= r_a_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_a_sq[l] <= n_side.mag[l] * n_side.mag[l];
            end
            r_a_side <= n_side;
            r_b_sum  <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
            r_b_side <= r_a_side;
        end
    end

    dsf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_val),
        .i_rad   (r_b_sum),
        .i_side  (r_b_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_comb begin
        dv_in.neg       = sq_side.neg;
        dv_in.vel       = sq_side.vel;
        dv_in.rest      = sq_side.rest;
        dv_in.k         = sq_side.k;
        dv_in.c         = sq_side.c;
        dv_in.norm      = sq_root;
        dv_in.too_close = (sq_root == 32'd0) || (sq_root < {1'b0, r_min_dist});
    end

    dsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_mag   (sq_side.mag),
        .i_side  (dv_in),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    dsf_force u_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_quo   (dv_quo),
        .i_side  (dv_side),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

[rtl/dsf_check.sv]
// Port-level checks for the damped spring force block, bound to the top level.
module dsf_check import dsf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.too_close) |->
            (o_data.force_x == '0 && o_data.force_y == '0 && o_data.force_z == '0))
        else $error("force given on a too-close result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule

bind damped_spring_force dsf_check u_check (.*);

[tb/damped_spring_force_test.sv]
// Testbench for damped_spring_force: random and edge-case joints against a force predictor.
`timescale 1ns / 1ps

module damped_spring_force_test;
    import dsf_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_item    i_data = '0;
    logic        i_cfg_we = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_item   o_data;

    t_in_item    joints_pending[$];
    t_out_item   forces_expected[$];
    logic [30:0] min_dist = MIN_DIST_RST;
    int          errors = 0;
    int          cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          send_busy = 1'b1;
    bit          recv_busy = 1'b1;
    bit          hold_off_req = 1'b0;
    int          hold_off_left = 0;

    damped_spring_force dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic signed [127:0] wide(input longint x);
        return 128'(x);
    endfunction

    function automatic t_out_item spring_force(input t_in_item j);
        longint                 d[3];
        longint                 u[3];
        logic [63:0]            sq;
        logic [63:0]            rest;
        logic [63:0]            root;
        logic [63:0]            one;
        logic signed [127:0]    dot;
        logic signed [127:0]    ext;
        logic signed [127:0]    s;
        logic signed [127:0]    f;
        logic signed [31:0]     fc[3];
        t_out_item              r;
        d[0] = j.delta_pos_x;
        d[1] = j.delta_pos_y;
        d[2] = j.delta_pos_z;
        sq = 0;
        for (int i = 0; i < 3; i++) sq += 64'(d[i] * d[i]);
        rest = sq;
        root = 0;
        one = 64'd1 << 62;
        while (one > rest) one >>= 2;
        while (one != 0) begin
            if (rest >= root + one) begin
                rest -= root + one;
                root = (root >> 1) + one;
            end else begin
                root >>= 1;
            end
            one >>= 2;
        end
        r = '0;
        if (root == 0 || root < 64'(min_dist)) begin
            r.too_close = 1'b1;
            return r;
        end
        dot = 0;
        for (int i = 0; i < 3; i++) u[i] = (d[i] * 64'sd1073741824) / longint'(root);
        dot = wide(u[0]) * wide(longint'(j.delta_vel_x))
            + wide(u[1]) * wide(longint'(j.delta_vel_y))
            + wide(u[2]) * wide(longint'(j.delta_vel_z));
        dot = dot >>> 30;
        ext = wide(longint'(root)) - wide(longint'({33'd0, j.rest_length}));
        s = ((wide(longint'(j.stiffness)) * ext) >>> 16)
          + ((wide(longint'(j.damping)) * dot) >>> 16);
        for (int i = 0; i < 3; i++) begin
            f = (wide(u[i]) * s) >>> 30;
            if (f > 128'sd2147483647) fc[i] = 32'sh7fffffff;
            else if (f < -128'sd2147483648) fc[i] = 32'sh80000000;
            else fc[i] = f[31:0];
        end
        r.force_x = fc[0];
        r.force_y = fc[1];
        r.force_z = fc[2];
        return r;
    endfunction

    function automatic logic [31:0] rand_coord(input int span);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom();
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    function automatic t_in_item rand_joint(input int span);
        t_in_item j;
        j.delta_pos_x = rand_coord(span);
        j.delta_pos_y = rand_coord(span);
        j.delta_pos_z = rand_coord(span);
        j.delta_vel_x = rand_coord(span);
        j.delta_vel_y = rand_coord(span);
        j.delta_vel_z = rand_coord(span);
        j.rest_length = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                                    : 31'($urandom_range(0, span));
        j.stiffness   = rand_coord(1 << 18);
        j.damping     = rand_coord(1 << 18);
        return j;
    endfunction

    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 19);
        if (p < 12) return 0;
        if (p < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("damped_spring_force_test NOT OK");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        logic     nxt_valid;
        t_in_item nxt_data;
        int       nxt_gap;
        nxt_valid = i_valid;
        nxt_data = i_data;
        nxt_gap = send_gap;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                forces_expected.push_back(spring_force(i_data));
                nxt_valid = 1'b0;
                nxt_gap = send_busy ? rand_gap() : 0;
            end
            if (!nxt_valid) begin
                if (nxt_gap > 0) begin
                    nxt_gap--;
                end else if (joints_pending.size() > 0) begin
                    nxt_data = joints_pending.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        i_valid <= nxt_valid;
        i_data <= nxt_data;
        send_gap <= nxt_gap;
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (forces_expected.size() == 0) begin
                $display("%0t: unexpected transfer, actual %h", $time, o_data);
                errors++;
            end else begin
                want = forces_expected.pop_front();
                if (o_data.force_x !== want.force_x)
                    $display("%0t: force_x expected %h actual %h",
                             $time, want.force_x, o_data.force_x);
                if (o_data.force_y !== want.force_y)
                    $display("%0t: force_y expected %h actual %h",
                             $time, want.force_y, o_data.force_y);
                if (o_data.force_z !== want.force_z)
                    $display("%0t: force_z expected %h actual %h",
                             $time, want.force_z, o_data.force_z);
                if (o_data.too_close !== want.too_close)
                    $display("%0t: too_close expected %b actual %b",
                             $time, want.too_close, o_data.too_close);
                if (o_data !== want) errors++;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_off_req && hold_off_left == 0) begin
            hold_off_left <= 300;
            i_stall <= 1'b1;
        end else if (hold_off_left > 1) begin
            hold_off_left <= hold_off_left - 1;
            i_stall <= 1'b1;
        end else if (hold_off_left == 1) begin
            hold_off_left <= -1;
            i_stall <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= 1'b1;
        end else begin
            recv_gap <= recv_busy ? rand_gap() : 0;
            i_stall <= 1'b0;
        end
    end

    task automatic set_min_distance(input logic [30:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        min_dist = value;
    endtask

    task automatic drain();
        while (joints_pending.size() > 0 || i_valid || forces_expected.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_joint(input logic [31:0] px, py, pz, vx, vy, vz,
                               input logic [30:0] rest, input logic [31:0] k, c);
        t_in_item j;
        j = '{px, py, pz, vx, vy, vz, rest, k, c};
        joints_pending.push_back(j);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        queue_joint(0, 0, 0, 5, 5, 5, 0, 32'h10000, 32'h10000);
        queue_joint(32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0);
        queue_joint(0, 32'hffff0000, 0, 32'h20000, 0, 0, 31'h8000, 32'h10000, 32'h10000);
        queue_joint(0, 0, 32'h30000, 0, 0, 32'hfffe0000, 31'h10000, 32'h28000, 32'h8000);
        queue_joint(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff);
        queue_joint(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 31'h7fffffff, 32'h80000000, 32'h80000000);
        queue_joint(32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 32'h80000000, 0,
                    31'h7fffffff, 32'h7fffffff, 32'h80000000);
        queue_joint(1, 0, 0, 0, 0, 0, 0, 32'h10000, 0);
        queue_joint(0, 0, 1, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff);
        queue_joint(32'h100, 32'h200, 32'h300, 32'h1000, 32'hfffff000, 0,
                    31'h10000000, 32'h7fffffff, 0);
        queue_joint(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 31'h1bb67, 32'h10000, 0);
        drain();

        set_min_distance(0);
        queue_joint(0, 0, 0, 1, 2, 3, 0, 32'h10000, 32'h10000);
        queue_joint(1, 1, 0, 1, 1, 1, 0, 32'h10000, 32'h10000);
        repeat (200) joints_pending.push_back(rand_joint(1 << 20));
        drain();

        set_min_distance(31'h7fffffff);
        queue_joint(32'h7fffffff, 0, 0, 0, 0, 0, 0, 32'h10000, 0);
        queue_joint(32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 32'h10000, 0);
        repeat (40) joints_pending.push_back(rand_joint(1 << 30));
        drain();

        set_min_distance(31'h40000);
        repeat (200) joints_pending.push_back(rand_joint(1 << 19));
        drain();

        // long hold-off with the sender offering back to back
        set_min_distance(31'h10000);
        send_busy = 1'b0;
        recv_busy = 1'b0;
        hold_off_req = 1'b1;
        repeat (150) joints_pending.push_back(rand_joint(1 << 24));
        wait (hold_off_left != 0);
        hold_off_req = 1'b0;
        drain();
        send_busy = 1'b1;
        recv_busy = 1'b1;

        set_min_distance(MIN_DIST_RST);
        repeat (120) joints_pending.push_back(rand_joint(1 << 26));
        drain();

        if (errors == 0) begin
            $display("damped_spring_force_test OK");
        end else begin
            $display("damped_spring_force_test NOT OK");
        end
        $finish;
    end

endmodule
